// ===== src/setf_pkg.sv =====
package setf_pkg;

  localparam int COORD_W = 9;
  localparam int START_W = 10;

  typedef logic [1:0] req_t;

  localparam req_t REQ_CLEAR = 2'd0;
  localparam req_t REQ_EDGE  = 2'd1;
  localparam req_t REQ_QUERY = 2'd2;

  typedef logic [COORD_W-1:0] coord_t;

endpackage

// ===== src/scanline_edge_table_fill.sv =====
// clear: one table row written per cycle by the sweep, over all CANVAS_SIZE rows
// edge: the restoring divider makes one quotient bit per cycle, then the walk
//   does one row per cycle and ST_WEND closes the edge;
//   a flat edge skips the divider and goes straight to the walk
// query: the table read is registered, then the result is registered into the output; one transaction at a time
// reset runs the clear sweep over all CANVAS_SIZE rows before in_ready goes high
module scanline_edge_table_fill
  import setf_pkg::*;
#(
  parameter int CANVAS_SIZE = 512,
  parameter int FRAC_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  req_t               in_req_type,
  input  coord_t             in_x_a,
  input  coord_t             in_y_a,
  input  coord_t             in_x_b,
  input  coord_t             in_y_b,
  input  coord_t             in_query_row,
  output logic               out_valid,
  input  logic               out_ready,
  output coord_t             out_span_row,
  output logic [START_W-1:0] out_span_start,
  output coord_t             out_span_end,
  output logic               out_span_nonempty
);

  localparam int ROW_W  = $clog2(CANVAS_SIZE);
  localparam int LEFT_W = ($clog2(CANVAS_SIZE + 1) > START_W) ?
                          $clog2(CANVAS_SIZE + 1) : START_W;
  localparam int ACC_W  = COORD_W + FRAC_BITS;
  localparam int DCNT_W = $clog2(ACC_W);

  localparam logic [LEFT_W-1:0] LEFT_INIT = LEFT_W'(CANVAS_SIZE);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(CANVAS_SIZE - 1);
  localparam logic [DCNT_W-1:0] DIV_LAST  = DCNT_W'(ACC_W - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_WALK,
    ST_WEND,
    ST_QRD
  } state_t;

  // table storage
  logic [LEFT_W-1:0]  left_mem  [CANVAS_SIZE];
  logic [COORD_W-1:0] right_mem [CANVAS_SIZE];
  logic [LEFT_W-1:0]  rd_l_r;
  logic [COORD_W-1:0] rd_r_r;
  logic [ROW_W-1:0]   rd_addr;
  logic               mem_we;
  logic [ROW_W-1:0]   wr_addr;
  logic [LEFT_W-1:0]  wr_l;
  logic [COORD_W-1:0] wr_r;

  state_t              state_r, state_nxt;
  logic [ROW_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [ACC_W-1:0]    dvd_r, dvd_nxt;
  logic [COORD_W-1:0]  rem_r, rem_nxt;
  logic [COORD_W-1:0]  dy_r, dy_nxt;
  logic [DCNT_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic                neg_r, neg_nxt;
  logic                horiz_r, horiz_nxt;
  logic [COORD_W-1:0]  xmax_r, xmax_nxt;
  logic [COORD_W-1:0]  y_r, y_nxt;
  logic [COORD_W-1:0]  yhi_r, yhi_nxt;
  logic [COORD_W-1:0]  qrow_r, qrow_nxt;
  logic                oor_r, oor_nxt;
  logic                p_vld_r, p_vld_nxt;
  logic [ROW_W-1:0]    p_row_r, p_row_nxt;
  logic [ACC_W-1:0]    p_xl_r, p_xl_nxt;
  logic [ACC_W-1:0]    p_xr_r, p_xr_nxt;
  logic                out_valid_r, out_valid_nxt;
  coord_t              out_row_r, out_row_nxt;
  logic [START_W-1:0]  out_start_r, out_start_nxt;
  coord_t              out_end_r, out_end_nxt;
  logic                out_ne_r, out_ne_nxt;

  logic               in_acc;
  logic               swap;
  coord_t             xlo, ylo, xhi, yhi;
  coord_t             adx;
  logic [COORD_W:0]   div_sh;
  logic               div_ge;
  logic [COORD_W:0]   div_diff;
  logic [31:0]        y_ext, q_ext, qr_ext;
  logic               y_in;
  logic               q_in;
  logic               out_load;
  logic [31:0]        l_val, r_val;
  coord_t             xl_int, xr_int;
  logic [31:0]        xl_ext;
  logic               left_upd, right_upd;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  // edge setup
  assign swap = in_y_b < in_y_a;
  assign xlo  = swap ? in_x_b : in_x_a;
  assign ylo  = swap ? in_y_b : in_y_a;
  assign xhi  = swap ? in_x_a : in_x_b;
  assign yhi  = swap ? in_y_a : in_y_b;
  assign adx  = (xhi >= xlo) ? (xhi - xlo) : (xlo - xhi);

  // restoring divider step
  assign div_sh   = {rem_r, dvd_r[ACC_W-1]};
  assign div_ge   = div_sh >= {1'b0, dy_r};
  assign div_diff = div_sh - {1'b0, dy_r};

  assign y_ext  = 32'(y_r);
  assign y_in   = y_ext < 32'(CANVAS_SIZE);
  assign q_ext  = 32'(in_query_row);
  assign q_in   = q_ext < 32'(CANVAS_SIZE);
  assign qr_ext = 32'(qrow_r);

  // read-modify-write stage of the walk
  assign xl_int    = p_xl_r[ACC_W-1 -: COORD_W];
  assign xr_int    = p_xr_r[ACC_W-1 -: COORD_W];
  assign xl_ext    = 32'(xl_int);
  assign left_upd  = xl_ext < 32'(rd_l_r);
  assign right_upd = p_xr_r > {rd_r_r, {FRAC_BITS{1'b0}}};

  always_comb begin
    if (state_r == ST_CLEAR) begin
      mem_we  = 1'b1;
      wr_addr = clr_cnt_r;
      wr_l    = LEFT_INIT;
      wr_r    = '0;
    end else begin
      mem_we  = p_vld_r;
      wr_addr = p_row_r;
      wr_l    = left_upd ? xl_ext[LEFT_W-1:0] : rd_l_r;
      wr_r    = right_upd ? xr_int : rd_r_r;
    end
  end

  always_comb begin
    unique case (state_r)
      ST_WALK: rd_addr = y_ext[ROW_W-1:0];
      ST_QRD:  rd_addr = qr_ext[ROW_W-1:0];
      default: rd_addr = q_ext[ROW_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      left_mem[wr_addr]  <= wr_l;
      right_mem[wr_addr] <= wr_r;
    end
    rd_l_r <= left_mem[rd_addr];
    rd_r_r <= right_mem[rd_addr];
  end

  // query result
  assign l_val    = oor_r ? 32'(CANVAS_SIZE) : 32'(rd_l_r);
  assign r_val    = oor_r ? 32'd0 : 32'(rd_r_r);
  assign out_load = (state_r == ST_QRD) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    dy_nxt        = dy_r;
    div_cnt_nxt   = div_cnt_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    horiz_nxt     = horiz_r;
    xmax_nxt      = xmax_r;
    y_nxt         = y_r;
    yhi_nxt       = yhi_r;
    qrow_nxt      = qrow_r;
    oor_nxt       = oor_r;
    p_vld_nxt     = 1'b0;
    p_row_nxt     = p_row_r;
    p_xl_nxt      = p_xl_r;
    p_xr_nxt      = p_xr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_row_nxt   = out_row_r;
    out_start_nxt = out_start_r;
    out_end_nxt   = out_end_r;
    out_ne_nxt    = out_ne_r;

    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ROW_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_req_type)
            REQ_CLEAR: begin
              clr_cnt_nxt = '0;
              state_nxt   = ST_CLEAR;
            end
            REQ_EDGE: begin
              y_nxt   = ylo;
              yhi_nxt = yhi;
              neg_nxt = xhi < xlo;
              dy_nxt  = yhi - ylo;
              rem_nxt = '0;
              div_cnt_nxt = DIV_LAST;
              if (yhi == ylo) begin
                // flat edge: one row widened by both end points
                horiz_nxt = 1'b1;
                acc_nxt   = {(in_x_a < in_x_b) ? in_x_a : in_x_b, {FRAC_BITS{1'b0}}};
                xmax_nxt  = (in_x_a < in_x_b) ? in_x_b : in_x_a;
                dvd_nxt   = '0;
                state_nxt = ST_WALK;
              end else begin
                horiz_nxt = 1'b0;
                acc_nxt   = {xlo, {FRAC_BITS{1'b0}}};
                dvd_nxt   = {adx, {FRAC_BITS{1'b0}}};
                state_nxt = ST_DIV;
              end
            end
            REQ_QUERY: begin
              qrow_nxt  = in_query_row;
              oor_nxt   = !q_in;
              state_nxt = ST_QRD;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        // dvd_r turns into the quotient bit by bit
        rem_nxt     = div_ge ? div_diff[COORD_W-1:0] : div_sh[COORD_W-1:0];
        dvd_nxt     = {dvd_r[ACC_W-2:0], div_ge};
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == '0) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        p_vld_nxt = y_in;
        p_row_nxt = y_ext[ROW_W-1:0];
        p_xl_nxt  = acc_r;
        p_xr_nxt  = horiz_r ? {xmax_r, {FRAC_BITS{1'b0}}} : acc_r;
        acc_nxt   = neg_r ? (acc_r - dvd_r) : (acc_r + dvd_r);
        if (y_r == yhi_r) begin
          state_nxt = ST_WEND;
        end else begin
          y_nxt = y_r + 1'b1;
        end
      end
      ST_WEND: begin
        state_nxt = ST_IDLE;
      end
      ST_QRD: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = qrow_r;
          out_start_nxt = l_val[START_W-1:0];
          out_end_nxt   = r_val[COORD_W-1:0];
          out_ne_nxt    = l_val < r_val;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      p_vld_r     <= p_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    dy_r        <= dy_nxt;
    div_cnt_r   <= div_cnt_nxt;
    acc_r       <= acc_nxt;
    neg_r       <= neg_nxt;
    horiz_r     <= horiz_nxt;
    xmax_r      <= xmax_nxt;
    y_r         <= y_nxt;
    yhi_r       <= yhi_nxt;
    qrow_r      <= qrow_nxt;
    oor_r       <= oor_nxt;
    p_row_r     <= p_row_nxt;
    p_xl_r      <= p_xl_nxt;
    p_xr_r      <= p_xr_nxt;
    out_row_r   <= out_row_nxt;
    out_start_r <= out_start_nxt;
    out_end_r   <= out_end_nxt;
    out_ne_r    <= out_ne_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_span_row      = out_row_r;
  assign out_span_start    = out_start_r;
  assign out_span_end      = out_end_r;
  assign out_span_nonempty = out_ne_r;

endmodule
